// File: hdl/hwm_pkg.sv
package hwm_pkg;

   localparam int PIX_W  = 32;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int ACT_W  = 2;
   localparam int SIDE_W = 7;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

   // round(2^31 / sqrt2) in Q0.31, and one half in the same scale
   localparam logic [30:0] INV_SQRT2_Q31 = 31'h5A82799A;
   localparam logic [30:0] HALF_Q31      = 31'h40000000;

   // magnitude of a sum or difference of two pixels, and its product
   localparam int MAG_W  = PIX_W + 1;
   localparam int PROD_W = MAG_W + 31;

   localparam logic [MAG_W-1:0] POS_LIMIT = 33'h07FFFFFFF;
   localparam logic [MAG_W-1:0] NEG_LIMIT = 33'h080000000;
   localparam logic [PIX_W-1:0] PIX_MAX   = 32'h7FFFFFFF;
   localparam logic [PIX_W-1:0] PIX_MIN   = 32'h80000000;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD  = 2'd0,
      ACT_XFORM = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } hwm_action_type;

   // controller -> datapath
   typedef struct packed {
      logic rd_en;        // read both store ports
      logic wr_load;      // write request pixel at port a
      logic wr_res;       // write rounded product
      logic wr_sel_b;     // ...at port b instead of a
      logic sum_en;       // form sum and difference
      logic mul_en;       // load product register
      logic mul_sel_dif;  // ...from the difference
      logic clip_clr;     // transform start
      logic push;         // result beat to response queue
      logic push_rd;      // ...carrying read data
   } hwm_cmd_type;

endpackage

// File: hdl/hwm_if.sv
interface hwm_req_if;
   logic                              valid;
   logic                              ready;
   logic [hwm_pkg::ACT_W-1:0]         action;
   logic [hwm_pkg::ROW_W-1:0]         row;
   logic [hwm_pkg::COL_W-1:0]         column;
   logic signed [hwm_pkg::PIX_W-1:0]  pixel_in;

   modport source (output valid, action, row, column, pixel_in, input ready);
   modport sink   (input valid, action, row, column, pixel_in, output ready);
endinterface

interface hwm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hwm_pkg::PIX_W-1:0]  pixel_out;
   logic                              saturated;

   modport source (output valid, pixel_out, saturated, input ready);
   modport sink   (input valid, pixel_out, saturated, output ready);
endinterface

// File: hdl/haar_wavelet_2d_multilevel_top.sv
// Channel   Dir  Beat contents                          Handshake
// req_ch    in   action, row, column, pixel_in          valid/ready
// rsp_ch    out  pixel_out, saturated                   valid/ready
// csr       in   side_length (7 bits)                   csr_wr_en, no stall
//
// Load and unused actions: result beat queued at accept.
// Read: the registered store read, then the queue push.
// Transform: per pixel pair a store read, sum/diff, then two passes through the one
//   33x31 multiplier; side 64 is 2730 pairs.
// Sync active-high reset clears control, clip flag and side (to 64), not the store.
// A two-beat response queue lets a new request in while a result waits.
module haar_wavelet_2d_multilevel_top #(
   parameter int MAX_SIDE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   hwm_req_if.sink                      req_ch,
   hwm_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [hwm_pkg::SIDE_W-1:0]   csr_wr_data
);

   localparam int CW = $clog2(MAX_SIDE);

   hwm_pkg::hwm_cmd_type              cmd;
   logic [CW-1:0]                     a_row, a_col, b_row, b_col;
   logic signed [hwm_pkg::PIX_W-1:0]  push_pixel;
   logic                              clip;
   logic                              rspq_not_full;

   // sequencer: request decode, level/pass/pair counters, side register
   hwm_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_action    (req_ch.action),
      .req_row       (req_ch.row),
      .req_column    (req_ch.column),
      .rspq_not_full (rspq_not_full),
      .cmd           (cmd),
      .a_row         (a_row),
      .a_col         (a_col),
      .b_row         (b_row),
      .b_col         (b_col)
   );

   // pixel store, butterfly arithmetic, rounding and clip flag
   hwm_dpath #(
      .MAX_SIDE (MAX_SIDE)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .a_row      (a_row),
      .a_col      (a_col),
      .b_row      (b_row),
      .b_col      (b_col),
      .pixel_in   (req_ch.pixel_in),
      .push_pixel (push_pixel),
      .clip       (clip)
   );

   // result beats; saturated reports the clip flag as of the push
   hwm_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd.push),
      .push_pixel (push_pixel),
      .push_sat   (clip),
      .out_valid  (rsp_ch.valid),
      .out_ready  (rsp_ch.ready),
      .out_pixel  (rsp_ch.pixel_out),
      .out_sat    (rsp_ch.saturated),
      .not_full   (rspq_not_full)
   );

endmodule

// File: hdl/hwm_ctrl.sv
module hwm_ctrl #(
   parameter int MAX_SIDE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [hwm_pkg::SIDE_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [hwm_pkg::ACT_W-1:0]         req_action,
   input  logic [hwm_pkg::ROW_W-1:0]         req_row,
   input  logic [hwm_pkg::COL_W-1:0]         req_column,
   input  logic                              rspq_not_full,
   output hwm_pkg::hwm_cmd_type              cmd,
   output logic [$clog2(MAX_SIDE)-1:0]       a_row,
   output logic [$clog2(MAX_SIDE)-1:0]       a_col,
   output logic [$clog2(MAX_SIDE)-1:0]       b_row,
   output logic [$clog2(MAX_SIDE)-1:0]       b_col
);

   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int LW = (SW > hwm_pkg::SIDE_W) ? SW : hwm_pkg::SIDE_W;
   localparam int PW = (CW > hwm_pkg::ROW_W) ? CW : hwm_pkg::ROW_W;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RDOUT = 9'b000000010,
      ST_LEVEL = 9'b000000100,
      ST_RD    = 9'b000001000,
      ST_SUM   = 9'b000010000,
      ST_MUL1  = 9'b000100000,
      ST_MUL2  = 9'b001000000,
      ST_WR2   = 9'b010000000,
      ST_DONE  = 9'b100000000
   } hwm_state_type;

   hwm_state_type               st_ff, st_in;
   logic [hwm_pkg::SIDE_W-1:0]  side_ff;
   logic [SW-1:0]               size_ff, size_in;
   logic [CW-1:0]               mid_ff, mid_in;
   logic [CW-1:0]               y_ff, y_in;
   logic [CW-1:0]               x_ff, x_in;
   logic                        colp_ff, colp_in;
   logic                        inside_ff, inside_in;

   logic                        accept;
   logic                        in_store;
   logic [SW-1:0]               eff_side;
   logic [CW-1:0]               req_r, req_c;
   logic                        x_last, y_last;

   assign req_ready = (st_ff == ST_IDLE) && rspq_not_full;
   assign accept    = req_valid && req_ready;

   assign in_store = (32'(req_row) < 32'(MAX_SIDE)) && (32'(req_column) < 32'(MAX_SIDE));
   assign req_r  = CW'(PW'(req_row));
   assign req_c  = CW'(PW'(req_column));

   // side above the store acts as the store side
   assign eff_side = (LW'(side_ff) > LW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(side_ff);

   assign x_last = (x_ff == mid_ff - CW'(1));
   assign y_last = (y_ff == mid_ff - CW'(1));

   assign a_row = (st_ff == ST_IDLE) ? req_r : y_ff;
   assign a_col = (st_ff == ST_IDLE) ? req_c : x_ff;
   assign b_row = colp_ff ? (mid_ff + y_ff) : y_ff;
   assign b_col = colp_ff ? x_ff : (mid_ff + x_ff);

   always_comb begin
      st_in     = st_ff;
      size_in   = size_ff;
      mid_in    = mid_ff;
      y_in      = y_ff;
      x_in      = x_ff;
      colp_in   = colp_ff;
      inside_in = inside_ff;
      cmd       = '0;
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (hwm_pkg::hwm_action_type'(req_action))
                  hwm_pkg::ACT_LOAD: begin
                     cmd.wr_load = in_store;
                     cmd.push    = 1'b1;
                  end
                  hwm_pkg::ACT_XFORM: begin
                     cmd.clip_clr = 1'b1;
                     size_in      = eff_side;
                     st_in        = ST_LEVEL;
                  end
                  hwm_pkg::ACT_READ: begin
                     cmd.rd_en = 1'b1;
                     inside_in = in_store;
                     st_in     = ST_RDOUT;
                  end
                  hwm_pkg::ACT_NONE: begin
                     cmd.push = 1'b1;
                  end
                  default: begin
                     cmd.push = 1'b1;
                  end
               endcase
            end
         end
         ST_RDOUT: begin
            cmd.push    = 1'b1;
            cmd.push_rd = inside_ff;
            st_in       = ST_IDLE;
         end
         ST_LEVEL: begin
            if (size_ff > SW'(1)) begin
               mid_in  = CW'(size_ff >> 1);
               y_in    = '0;
               x_in    = '0;
               colp_in = 1'b0;
               st_in   = ST_RD;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_RD: begin
            cmd.rd_en = 1'b1;
            st_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_en = 1'b1;
            st_in      = ST_MUL1;
         end
         ST_MUL1: begin
            cmd.mul_en = 1'b1;
            st_in      = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.wr_res      = 1'b1;
            cmd.mul_en      = 1'b1;
            cmd.mul_sel_dif = 1'b1;
            st_in           = ST_WR2;
         end
         ST_WR2: begin
            cmd.wr_res   = 1'b1;
            cmd.wr_sel_b = 1'b1;
            st_in        = ST_RD;
            if (x_last) begin
               x_in = '0;
               if (y_last) begin
                  y_in = '0;
                  if (colp_ff) begin
                     size_in = SW'(mid_ff);
                     st_in   = ST_LEVEL;
                  end else begin
                     colp_in = 1'b1;
                  end
               end else begin
                  y_in = y_ff + CW'(1);
               end
            end else begin
               x_in = x_ff + CW'(1);
            end
         end
         ST_DONE: begin
            cmd.push = 1'b1;
            st_in    = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         side_ff <= hwm_pkg::SIDE_RESET;
      end else begin
         st_ff <= st_in;
         if (csr_wr_en) begin
            side_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff   <= size_in;
      mid_ff    <= mid_in;
      y_ff      <= y_in;
      x_ff      <= x_in;
      colp_ff   <= colp_in;
      inside_ff <= inside_in;
   end

endmodule

// File: hdl/hwm_dpath.sv
module hwm_dpath #(
   parameter int MAX_SIDE = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hwm_pkg::hwm_cmd_type              cmd,
   input  logic [$clog2(MAX_SIDE)-1:0]       a_row,
   input  logic [$clog2(MAX_SIDE)-1:0]       a_col,
   input  logic [$clog2(MAX_SIDE)-1:0]       b_row,
   input  logic [$clog2(MAX_SIDE)-1:0]       b_col,
   input  logic signed [hwm_pkg::PIX_W-1:0]  pixel_in,
   output logic signed [hwm_pkg::PIX_W-1:0]  push_pixel,
   output logic                              clip
);

   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int PIX_W = hwm_pkg::PIX_W;
   localparam int MAG_W = hwm_pkg::MAG_W;

   logic signed [PIX_W-1:0]  image_store_ff [DEPTH];
   logic signed [PIX_W-1:0]  rda_ff, rdb_ff;
   logic [MAG_W-1:0]         sum_mag_ff, dif_mag_ff;
   logic                     sum_neg_ff, dif_neg_ff;
   logic [hwm_pkg::PROD_W-1:0] prod_ff;
   logic                     prod_neg_ff;
   logic                     clip_ff;

   logic [AW-1:0]            addr_a, addr_b, waddr;
   logic                     wen;
   logic [PIX_W-1:0]         wdata;
   logic signed [MAG_W-1:0]  sum, dif;
   logic [MAG_W-1:0]         mul_mag;
   logic [MAG_W-1:0]         q, qr;
   logic [30:0]              rem;
   logic                     up;
   logic [PIX_W-1:0]         res;
   logic                     sat;

   assign addr_a = AW'(a_row) * AW'(MAX_SIDE) + AW'(a_col);
   assign addr_b = AW'(b_row) * AW'(MAX_SIDE) + AW'(b_col);

   assign sum = {rda_ff[PIX_W-1], rda_ff} + {rdb_ff[PIX_W-1], rdb_ff};
   assign dif = {rda_ff[PIX_W-1], rda_ff} - {rdb_ff[PIX_W-1], rdb_ff};

   assign mul_mag = cmd.mul_sel_dif ? dif_mag_ff : sum_mag_ff;

   // shift by 31, round half to even, then clip to 32 bits
   assign q   = prod_ff[hwm_pkg::PROD_W-1:31];
   assign rem = prod_ff[30:0];
   assign up  = (rem > hwm_pkg::HALF_Q31) || ((rem == hwm_pkg::HALF_Q31) && q[0]);
   assign qr  = q + MAG_W'(up);

   always_comb begin
      if (!prod_neg_ff) begin
         sat = (qr > hwm_pkg::POS_LIMIT);
         res = sat ? hwm_pkg::PIX_MAX : qr[PIX_W-1:0];
      end else begin
         sat = (qr > hwm_pkg::NEG_LIMIT);
         res = sat ? hwm_pkg::PIX_MIN : PIX_W'(MAG_W'(0) - qr);
      end
   end

   assign wen   = cmd.wr_load || cmd.wr_res;
   assign waddr = (cmd.wr_res && cmd.wr_sel_b) ? addr_b : addr_a;
   assign wdata = cmd.wr_load ? pixel_in : res;

   always_ff @(posedge clock) begin
      if (wen) begin
         image_store_ff[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rda_ff <= image_store_ff[addr_a];
         rdb_ff <= image_store_ff[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sum_neg_ff <= sum[MAG_W-1];
         sum_mag_ff <= sum[MAG_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
         dif_neg_ff <= dif[MAG_W-1];
         dif_mag_ff <= dif[MAG_W-1] ? MAG_W'(-dif) : MAG_W'(dif);
      end
      if (cmd.mul_en) begin
         prod_ff     <= hwm_pkg::PROD_W'(mul_mag) * hwm_pkg::PROD_W'(hwm_pkg::INV_SQRT2_Q31);
         prod_neg_ff <= cmd.mul_sel_dif ? dif_neg_ff : sum_neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= 1'b0;
      end else if (cmd.clip_clr) begin
         clip_ff <= 1'b0;
      end else if (cmd.wr_res && sat) begin
         clip_ff <= 1'b1;
      end
   end

   assign push_pixel = cmd.push_rd ? rda_ff : '0;
   assign clip       = clip_ff;

endmodule

// File: hdl/hwm_rspq.sv
module hwm_rspq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  logic signed [hwm_pkg::PIX_W-1:0]  push_pixel,
   input  logic                              push_sat,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [hwm_pkg::PIX_W-1:0]  out_pixel,
   output logic                              out_sat,
   output logic                              not_full
);

   localparam int DW = hwm_pkg::PIX_W + 1;

   logic [1:0]    cnt_ff, cnt_in;
   logic [DW-1:0] head_ff, head_in;
   logic [DW-1:0] tail_ff, tail_in;
   logic [DW-1:0] din;
   logic          pop;

   assign din = {push_sat, push_pixel};
   assign pop = out_valid && out_ready;

   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = din;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = din;
            end else if (push) begin
               tail_in = din;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
               if (push) begin
                  tail_in = din;
               end else begin
                  cnt_in = 2'd1;
               end
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign out_valid = (cnt_ff != 2'd0);
   assign out_pixel = head_ff[DW-2:0];
   assign out_sat   = head_ff[DW-1];
   assign not_full  = (cnt_ff != 2'd2);

endmodule
